// ----- hdl/rc6_frame_symbol_generator_macros.svh -----
// Assertion macros shared by the RC6 frame symbol generator modules.
`ifndef RC6_FRAME_SYMBOL_GENERATOR_MACROS_SVH
`define RC6_FRAME_SYMBOL_GENERATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RC6FSG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RC6FSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rc6fsg_pkg.sv -----
// Package with types and constants of the RC6 frame symbol generator.
`default_nettype none

package rc6fsg_pkg;

  localparam int CMD_W       = 8;
  localparam int UNIT_W      = 10;
  localparam int DUR_W       = 13;
  localparam int TDATA_W     = 16;

  localparam logic [UNIT_W-1:0] UNIT_RESET       = UNIT_W'(444);
  localparam logic [CMD_W-1:0]  PREV_COMMAND_RST = CMD_W'(8'hff);

  localparam int FRAME_LEN   = 46;
  localparam int IDX_W       = $clog2(FRAME_LEN);

  localparam int TRIM_ONE_HI  = 10;
  localparam int TRIM_ONE_LO  = 55;
  localparam int TRIM_ZERO_LO = 4;
  localparam int TRIM_ZERO_HI = 25;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             rep;
    logic             tog;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

// ----- hdl/rc6fsg_front.sv -----
// Front part: takes send requests, drops repeats and busy ones, queues frames.
`default_nettype none

module rc6fsg_front
  import rc6fsg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [CMD_W-1:0]   in_cmd,
  input  wire logic               in_rep,
  input  wire logic               in_busy,
  input  wire queue_status_t      queue_status,
  output logic                    push,
  output job_t                    push_job
);

  logic [CMD_W-1:0] last_command;
  logic             toggle_flag;
  logic             take;

  assign in_ready = !queue_status.full;
  assign take     = in_valid && in_ready;
  assign push     = take && !in_busy && (in_cmd != last_command);

  always_comb begin
    push_job.cmd = in_cmd;
    push_job.rep = in_rep;
    push_job.tog = toggle_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_command <= PREV_COMMAND_RST;
      toggle_flag  <= 1'b0;
    end else if (push) begin
      last_command <= in_cmd;
      toggle_flag  <= !toggle_flag;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rc6fsg_queue.sv -----
// Short queue of accepted frames between the front and back parts.
`default_nettype none

module rc6fsg_queue
  import rc6fsg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire job_t     push_job,
  input  wire logic     pop,
  output job_t          pop_job,
  output queue_status_t status
);

  `include "rc6_frame_symbol_generator_macros.svh"

  job_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign status.full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_job      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `RC6FSG_ASSERT_SAME(a_no_overflow, push, !status.full || pop, "push into full queue")
  `RC6FSG_ASSERT_SAME(a_no_underflow, pop, !status.empty, "pop from empty queue")
  `RC6FSG_ASSERT_NEXT(a_push_seen, push && !pop, !status.empty, "pushed frame lost")

endmodule

`default_nettype wire

// ----- hdl/rc6fsg_back.sv -----
// Back part: steps through the 46 half-symbols of a frame into an output register.
`default_nettype none

module rc6fsg_back
  import rc6fsg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [UNIT_W-1:0]  unit_period,
  input  wire queue_status_t      queue_status,
  input  wire job_t               pop_job,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_level,
  output logic [DUR_W-1:0]        out_dur,
  output logic                    out_last,
  output logic                    out_rep
);

  `include "rc6_frame_symbol_generator_macros.svh"

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  job_t              job;
  logic              active;
  logic [IDX_W-1:0]  idx;
  logic              load;
  logic              bit_val;
  logic              second_half;
  logic [IDX_W-1:0]  cmd_off;
  logic [2:0]        cmd_sel;
  logic [DUR_W-1:0]  t_ext;
  logic              level_next;
  logic [DUR_W-1:0]  dur_next;

  assign load = active && (!out_valid || out_ready);
  assign pop  = !queue_status.empty && (!active || (load && idx == LAST_IDX));

  assign t_ext   = DUR_W'(unit_period);
  assign cmd_off = idx - IDX_W'(30);
  assign cmd_sel = cmd_off[3:1];

  always_comb begin
    bit_val     = 1'b0;
    second_half = idx[0];
    if (idx < IDX_W'(4)) begin
      bit_val = 1'b1;
    end else if (idx < IDX_W'(10)) begin
      bit_val = 1'b0;
    end else if (idx < IDX_W'(14)) begin
      bit_val     = job.tog;
      second_half = !idx[1];
    end else if (idx < IDX_W'(30)) begin
      bit_val = 1'b0;
    end else begin
      bit_val = job.cmd[3'd7 - cmd_sel];
    end
  end

  always_comb begin
    if (idx == IDX_W'(0)) begin
      level_next = 1'b1;
      dur_next   = (t_ext << 2) + (t_ext << 1);
    end else if (idx == IDX_W'(1)) begin
      level_next = 1'b0;
      dur_next   = t_ext << 1;
    end else if (bit_val && !second_half) begin
      level_next = 1'b1;
      dur_next   = t_ext + DUR_W'(TRIM_ONE_HI);
    end else if (bit_val) begin
      level_next = 1'b0;
      dur_next   = t_ext + DUR_W'(TRIM_ONE_LO);
    end else if (!second_half) begin
      level_next = 1'b0;
      dur_next   = t_ext + DUR_W'(TRIM_ZERO_LO);
    end else begin
      level_next = 1'b1;
      dur_next   = t_ext + DUR_W'(TRIM_ZERO_HI);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (pop) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (load) begin
      if (idx == LAST_IDX) begin
        active <= 1'b0;
        idx    <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= pop_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_level <= level_next;
      out_dur   <= dur_next;
      out_last  <= (idx == LAST_IDX);
      out_rep   <= job.rep;
    end
  end

  `RC6FSG_ASSERT_SAME(a_idx_range, active, idx <= LAST_IDX, "half-symbol index past frame end")
  `RC6FSG_ASSERT_NEXT(a_frame_end, load && idx == LAST_IDX && !pop,
                      !active && out_last, "frame did not close after last half-symbol")
  `RC6FSG_ASSERT_NEXT(a_frame_start, load && idx == '0,
                      out_valid && out_level && !out_last, "frame does not open with leader")

endmodule

`default_nettype wire

// ----- hdl/rc6_frame_symbol_generator.sv -----
// Top level of the RC6 frame symbol generator.
// From idle, an accepted command goes via a queue entry and the job registers to the output register.
// A frame is 46 half-symbols, sent at one per cycle while the output is not held off.
// The two-entry frame queue lets requests keep flowing, dropped ones at one per cycle while it is not full.
// Synchronous reset sets T to 444, the last command to 255, the toggle bit to 0 and empties the queue.
`default_nettype none

module rc6_frame_symbol_generator
  import rc6fsg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [UNIT_W-1:0]  cfg_wr_data,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // Fields from bit 0: command_byte[7:0], want_repeat, busy_req, zero fill.
  input  wire logic [TDATA_W-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // Fields from bit 0: level, duration_us[12:0], repeat flag, zero fill.
  output logic [TDATA_W-1:0]      m_axis_tdata,
  output logic                    m_axis_tlast
);

  logic [UNIT_W-1:0] unit_period;
  queue_status_t     queue_status;
  logic              push;
  job_t              push_job;
  logic              pop;
  job_t              pop_job;
  logic              out_level;
  logic [DUR_W-1:0]  out_dur;
  logic              out_rep;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_period <= UNIT_RESET;
    end else if (cfg_wr_en) begin
      unit_period <= cfg_wr_data;
    end
  end

  rc6fsg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_cmd       (s_axis_tdata[7:0]),
    .in_rep       (s_axis_tdata[8]),
    .in_busy      (s_axis_tdata[9]),
    .queue_status (queue_status),
    .push         (push),
    .push_job     (push_job)
  );

  rc6fsg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (queue_status)
  );

  rc6fsg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .unit_period  (unit_period),
    .queue_status (queue_status),
    .pop_job      (pop_job),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_level    (out_level),
    .out_dur      (out_dur),
    .out_last     (m_axis_tlast),
    .out_rep      (out_rep)
  );

  assign m_axis_tdata = {1'b0, out_rep, out_dur, out_level};

endmodule

`default_nettype wire

// ----- dv/rc6_frame_symbol_generator_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the RC6 frame symbol generator with a predicting scoreboard.

import rc6fsg_pkg::*;

typedef struct packed {
  logic             level;
  logic [DUR_W-1:0] duration;
  logic             tail;
  logic             repeat_en;
} half_symbol_t;

class symbol_scoreboard;
  localparam int ONE_HI_TRIM  = 10;
  localparam int ONE_LO_TRIM  = 55;
  localparam int ZERO_LO_TRIM = 4;
  localparam int ZERO_HI_TRIM = 25;

  logic [UNIT_W-1:0] unit_us;
  logic [CMD_W-1:0]  prev_sent;
  logic              toggle;
  logic              frame_rep;
  int                frame_pos;
  int                frames;
  int                symbols_checked;
  int                errors;
  half_symbol_t      pending_symbols[$];

  function new();
    unit_us = UNIT_RESET;
    prev_sent = PREV_COMMAND_RST;
    toggle = 1'b0;
    frame_rep = 1'b0;
    frame_pos = 0;
    frames = 0;
    symbols_checked = 0;
    errors = 0;
  endfunction

  function void set_unit(logic [UNIT_W-1:0] value);
    unit_us = value;
  endfunction

  function void push_half(logic lvl, int dur);
    half_symbol_t s;
    s.level = lvl;
    s.duration = DUR_W'(dur);
    s.tail = (frame_pos == FRAME_LEN - 1);
    s.repeat_en = frame_rep;
    pending_symbols.push_back(s);
    frame_pos++;
  endfunction

  function void push_bit(logic b);
    int t;
    t = int'(unit_us);
    if (b) begin
      push_half(1'b1, t + ONE_HI_TRIM);
      push_half(1'b0, t + ONE_LO_TRIM);
    end else begin
      push_half(1'b0, t + ZERO_LO_TRIM);
      push_half(1'b1, t + ZERO_HI_TRIM);
    end
  endfunction

  // A busy request or a repeat of the last sent command produces nothing.
  function void note_request(logic [CMD_W-1:0] cmd, logic rep, logic busy);
    int t;
    if (busy || cmd == prev_sent) return;
    prev_sent = cmd;
    frame_rep = rep;
    frame_pos = 0;
    t = int'(unit_us);
    push_half(1'b1, 6 * t);
    push_half(1'b0, 2 * t);
    push_bit(1'b1);
    for (int i = 0; i < 3; i++) push_bit(1'b0);
    if (toggle) begin
      push_half(1'b1, t + ONE_HI_TRIM);
      push_half(1'b1, t + ONE_HI_TRIM);
      push_half(1'b0, t + ONE_LO_TRIM);
      push_half(1'b0, t + ONE_LO_TRIM);
    end else begin
      push_half(1'b0, t + ZERO_LO_TRIM);
      push_half(1'b0, t + ZERO_LO_TRIM);
      push_half(1'b1, t + ZERO_HI_TRIM);
      push_half(1'b1, t + ZERO_HI_TRIM);
    end
    toggle = ~toggle;
    for (int i = 0; i < 8; i++) push_bit(1'b0);
    for (int i = CMD_W - 1; i >= 0; i--) push_bit(cmd[i]);
    frames++;
  endfunction

  function void check_symbol(logic [TDATA_W-1:0] data, logic last);
    half_symbol_t exp_s;
    symbols_checked++;
    if (pending_symbols.size() == 0) begin
      $error("unexpected half-symbol: tdata %h tlast %b", data, last);
      errors++;
      return;
    end
    exp_s = pending_symbols.pop_front();
    if (data[0] !== exp_s.level) begin
      $error("level: expected %0d, actual %0d", exp_s.level, data[0]);
      errors++;
    end
    if (data[DUR_W:1] !== exp_s.duration) begin
      $error("duration_us: expected %0d, actual %0d", exp_s.duration, data[DUR_W:1]);
      errors++;
    end
    if (last !== exp_s.tail) begin
      $error("final_item: expected %0d, actual %0d", exp_s.tail, last);
      errors++;
    end
    if (data[DUR_W+1] !== exp_s.repeat_en) begin
      $error("repeat_en: expected %0d, actual %0d", exp_s.repeat_en, data[DUR_W+1]);
      errors++;
    end
  endfunction
endclass

module rc6_frame_symbol_generator_test;
  localparam int IDLE_LIMIT       = 2000;
  localparam int HOLD_CYCLES      = 400;
  localparam int HOLD_AFTER       = 1500;
  localparam int SETTLE_CYCLES    = 20;
  localparam int FRAMES_PER_PHASE = 35;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [UNIT_W-1:0]  cfg_wr_data;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;

  logic             steady = 1'b0;
  logic             hold_done = 1'b0;
  int               idle_cycles;
  symbol_scoreboard sb = new();

  rc6_frame_symbol_generator u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_request(logic [CMD_W-1:0] cmd, logic rep, logic busy);
    s_axis_tdata <= TDATA_W'({busy, rep, cmd});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(cmd, rep, busy);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_unit(logic [UNIT_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_unit(value);
  endtask

  // Mostly fresh commands that produce frames, the rest busy or repeated requests.
  task automatic run_random_phase(int n_frames);
    int               target;
    int               pick;
    logic [CMD_W-1:0] cmd;
    logic             busy;
    target = sb.frames + n_frames;
    while (sb.frames < target) begin
      if (!steady && $urandom_range(99) < 25) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end
      pick = $urandom_range(99);
      cmd = CMD_W'($urandom);
      busy = 1'b0;
      if (pick < 70) begin
        while (cmd == sb.prev_sent) cmd = CMD_W'($urandom);
      end else if (pick < 85) begin
        busy = 1'b1;
      end else begin
        cmd = sb.prev_sent;
      end
      send_request(cmd, 1'($urandom_range(1)), busy);
    end
  endtask

  initial begin
    logic [UNIT_W-1:0] unit_steps [5];
    unit_steps[0] = '0;
    unit_steps[1] = '1;
    unit_steps[2] = UNIT_W'(100);
    unit_steps[3] = UNIT_W'(1000);
    unit_steps[4] = UNIT_W'($urandom_range(1, 1022));
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'ha5, 1'b0, 1'b0);
    send_request(8'h5a, 1'b1, 1'b1);
    send_request(8'h5a, 1'b1, 1'b0);
    send_request(8'h80, 1'b0, 1'b0);
    send_request(8'h01, 1'b1, 1'b0);
    send_request(8'h01, 1'b0, 1'b0);
    send_request(8'hfe, 1'b0, 1'b0);

    for (int i = 0; i < 5; i++) begin
      wait_idle();
      write_unit(unit_steps[i]);
      steady = (i == 3);
      run_random_phase(FRAMES_PER_PHASE);
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending_symbols.size() == 0) begin
      $display("rc6_frame_symbol_generator_test passed");
    end else begin
      $display("rc6_frame_symbol_generator_test failed");
    end
    $finish;
  end

  // Output side, with one long hold-off that backs the frame queue up into the input.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        sb.check_symbol(m_axis_tdata, m_axis_tlast);
      end
      if (!hold_done && sb.symbols_checked >= HOLD_AFTER) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 25);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_wr_en || (s_axis_tvalid && s_axis_tready)
          || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("rc6_frame_symbol_generator_test failed");
    $finish;
  end
endmodule
